### rtl/slfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfu_pkg
// Shared types, register codes and byte helpers of the store-to-load
// forwarding unit.
// ----------------------------------------------------------------------------
package slfu_pkg;

   localparam int ADDR_W     = 64;
   localparam int DATA_W     = 64;
   localparam int SIZE_W     = 2;
   localparam int ALIGN_W    = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr[2]
   localparam logic REG_LITTLE_ENDIAN = 1'b0;
   localparam logic REG_ALIGN_LOG2    = 1'b1;

   // access size codes
   localparam logic [SIZE_W-1:0] SIZE_1 = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_2 = 2'd1;
   localparam logic [SIZE_W-1:0] SIZE_4 = 2'd2;
   localparam logic [SIZE_W-1:0] SIZE_8 = 2'd3;

   localparam logic [7:0] BYTE_MASK = 8'hff;

   typedef struct packed {
      logic               little_endian;
      logic [ALIGN_W-1:0] alignment_log2;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] load_addr;
      logic [SIZE_W-1:0] load_size_code;
      logic [DATA_W-1:0] load_value;
      logic [ADDR_W-1:0] store_addr;
      logic [SIZE_W-1:0] store_size_code;
      logic [DATA_W-1:0] store_value;
   } req_type;

   typedef struct packed {
      logic              overlap;
      logic              aligned_overlap;
      logic              load_inside;
      logic [DATA_W-1:0] forward_value;
      logic [DATA_W-1:0] merged_value;
   } rsp_type;

   // access size in bytes, 1 to 8
   function automatic logic [3:0] size_bytes(input logic [SIZE_W-1:0] code);
      return 4'd1 << code;
   endfunction

   // reverse the low bytes of the access; drop the bytes above it
   function automatic logic [DATA_W-1:0] swap_bytes(input logic [DATA_W-1:0] v,
                                                   input logic [SIZE_W-1:0] code);
      logic [DATA_W-1:0] r;
      r = '0;
      case (code)
         SIZE_1: r = {56'b0, v[7:0]};
         SIZE_2: r = {48'b0, v[7:0], v[15:8]};
         SIZE_4: r = {32'b0, v[7:0], v[15:8], v[23:16], v[31:24]};
         SIZE_8: r = {v[7:0], v[15:8], v[23:16], v[31:24],
                      v[39:32], v[47:40], v[55:48], v[63:56]};
         default: r = '0;
      endcase
      return r;
   endfunction

   // keep only the low bytes of the access
   function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] v,
                                                   input logic [SIZE_W-1:0] code);
      logic [DATA_W-1:0] r;
      r = '0;
      case (code)
         SIZE_1: r = {56'b0, v[7:0]};
         SIZE_2: r = {48'b0, v[15:0]};
         SIZE_4: r = {32'b0, v[31:0]};
         SIZE_8: r = v;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/slfu_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfu_req_if
// Request channel: one load/store pair per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface slfu_req_if;
   logic                                valid;
   logic                                ready;
   logic [slfu_pkg::ADDR_W-1:0]         load_addr;
   logic [slfu_pkg::SIZE_W-1:0]         load_size_code;
   logic [slfu_pkg::DATA_W-1:0]         load_value;
   logic [slfu_pkg::ADDR_W-1:0]         store_addr;
   logic [slfu_pkg::SIZE_W-1:0]         store_size_code;
   logic [slfu_pkg::DATA_W-1:0]         store_value;

   modport source (
      output valid, load_addr, load_size_code, load_value,
             store_addr, store_size_code, store_value,
      input  ready
   );

   modport sink (
      input  valid, load_addr, load_size_code, load_value,
             store_addr, store_size_code, store_value,
      output ready
   );
endinterface
`default_nettype wire

### rtl/slfu_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfu_rsp_if
// Result channel: overlap checks and forwarded/merged values.
// ----------------------------------------------------------------------------
interface slfu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        overlap;
   logic                        aligned_overlap;
   logic                        load_inside;
   logic [slfu_pkg::DATA_W-1:0] forward_value;
   logic [slfu_pkg::DATA_W-1:0] merged_value;

   modport source (
      output valid, overlap, aligned_overlap, load_inside, forward_value, merged_value,
      input  ready
   );

   modport sink (
      input  valid, overlap, aligned_overlap, load_inside, forward_value, merged_value,
      output ready
   );
endinterface
`default_nettype wire

### rtl/slfu_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfu_csr
// APB register file: endianness and alignment block size.
// ----------------------------------------------------------------------------
module slfu_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [slfu_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [slfu_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [slfu_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                     pready,
   output slfu_pkg::cfg_type                        cfg
);

   logic                             little_endian_ff, little_endian_in;
   logic [slfu_pkg::ALIGN_W-1:0]     align_log2_ff, align_log2_in;
   logic                             wr_en;
   logic                             reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      little_endian_in = little_endian_ff;
      align_log2_in    = align_log2_ff;
      if (wr_en) begin
         case (reg_sel)
            slfu_pkg::REG_LITTLE_ENDIAN: little_endian_in = pwdata[0];
            slfu_pkg::REG_ALIGN_LOG2:    align_log2_in    = pwdata[slfu_pkg::ALIGN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         little_endian_ff <= 1'b0;
         align_log2_ff    <= '0;
      end else begin
         little_endian_ff <= little_endian_in;
         align_log2_ff    <= align_log2_in;
      end
   end

   always_comb begin
      case (reg_sel)
         slfu_pkg::REG_LITTLE_ENDIAN: prdata = {31'b0, little_endian_ff};
         slfu_pkg::REG_ALIGN_LOG2:    prdata = {26'b0, align_log2_ff};
         default:                     prdata = '0;
      endcase
   end

   assign cfg.little_endian  = little_endian_ff;
   assign cfg.alignment_log2 = align_log2_ff;

endmodule
`default_nettype wire

### rtl/slfu_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfu_core
// Overlap checks, forwarding extract and byte merge for one request.
// ----------------------------------------------------------------------------
module slfu_core (
   input  slfu_pkg::req_type  req,
   input  slfu_pkg::cfg_type  cfg,
   output slfu_pkg::rsp_type  rsp
);

   logic [slfu_pkg::ADDR_W-1:0] load_end;
   logic [slfu_pkg::ADDR_W-1:0] store_end;
   logic [slfu_pkg::ADDR_W-1:0] align_mask;
   logic [slfu_pkg::ADDR_W-1:0] dist_ge;
   logic [slfu_pkg::ADDR_W-1:0] dist_lt;
   logic [3:0]                  load_bytes;
   logic [3:0]                  store_bytes;
   logic                        load_ge;
   logic                        near_ge;
   logic                        near_lt;
   logic [2:0]                  byte_dist;
   logic                        load_in_store;
   logic [slfu_pkg::DATA_W-1:0] store_image;
   logic [slfu_pkg::DATA_W-1:0] fwd_part;

   assign load_bytes  = slfu_pkg::size_bytes(req.load_size_code);
   assign store_bytes = slfu_pkg::size_bytes(req.store_size_code);
   assign load_end    = req.load_addr + 64'(load_bytes);
   assign store_end   = req.store_addr + 64'(store_bytes);
   assign align_mask  = ~64'd0 << cfg.alignment_log2;

   assign load_ge   = req.load_addr >= req.store_addr;
   assign dist_ge   = req.load_addr - req.store_addr;
   assign dist_lt   = req.store_addr - req.load_addr;
   assign near_ge   = load_ge && (dist_ge[63:3] == '0);
   assign near_lt   = !load_ge && (dist_lt[63:3] == '0);
   assign byte_dist = load_ge ? dist_ge[2:0] : dist_lt[2:0];

   assign load_in_store = (req.store_addr <= req.load_addr) && (load_end <= store_end);

   assign store_image = cfg.little_endian ? req.store_value
                      : slfu_pkg::swap_bytes(req.store_value, req.store_size_code);

   assign fwd_part = slfu_pkg::keep_bytes(store_image >> {byte_dist, 3'b000},
                                          req.load_size_code);

   always_comb begin
      rsp.overlap = ((req.load_addr <= req.store_addr) && (req.store_addr < load_end)) ||
                    ((req.store_addr <= req.load_addr) && (req.load_addr < store_end));
      rsp.aligned_overlap = ((req.load_addr ^ req.store_addr) & align_mask) == '0;
      rsp.load_inside     = load_in_store;
      // inside implies the load is at or above the store
      if (load_in_store && near_ge) begin
         rsp.forward_value = cfg.little_endian ? fwd_part
                           : slfu_pkg::swap_bytes(fwd_part, req.load_size_code);
      end else begin
         rsp.forward_value = '0;
      end
   end

   // one lane per load byte: pick the store byte that lands there, if any
   always_comb begin
      logic [3:0] idx;
      logic       take;
      rsp.merged_value = req.load_value;
      for (int p = 0; p < 8; p++) begin
         if (load_ge) begin
            idx  = {1'b0, 3'(p)} + {1'b0, byte_dist};
            take = near_ge && (idx < store_bytes) && (4'(p) < load_bytes);
         end else begin
            idx  = {1'b0, 3'(p)} - {1'b0, byte_dist};
            take = near_lt && (3'(p) >= byte_dist) && (idx < store_bytes) &&
                   (4'(p) < load_bytes);
         end
         if (take) begin
            rsp.merged_value[8*p +: 8] = store_image[{idx[2:0], 3'b000} +: 8]
                                         & slfu_pkg::BYTE_MASK;
         end
      end
   end

endmodule
`default_nettype wire

### rtl/store_load_forwarding_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// store_load_forwarding_unit
// Checks a younger load against an older store and forwards/merges bytes.
//
// Requests enter on req_ch (valid/ready): load and store address, size code
// and register value. Each request yields exactly one result on rsp_ch:
// byte overlap, same aligned block, load inside store, the forwarded load
// value and the load value with the overlapping store bytes merged in.
// An accepted request passes the request register, the checks and byte
// lanes in one combinational pass, then the result register, which drives
// rsp_ch.valid. Throughput is one request per cycle; ready falls only when
// both registers hold data and the receiver stalls, and a held result
// stays stable until taken. Endianness and alignment block size are set
// through the APB port (0x0 little_endian, 0x4 alignment_log2); the user
// must write them only while the unit is empty, the unit does not enforce
// this. Synchronous reset empties both stages and clears the registers to
// big endian and a one-byte block.
// ----------------------------------------------------------------------------
module store_load_forwarding_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   slfu_req_if.sink                              req_ch,
   slfu_rsp_if.source                            rsp_ch,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [slfu_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [slfu_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [slfu_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready
);

   slfu_pkg::cfg_type cfg;
   slfu_pkg::req_type req_in, req_ff;
   slfu_pkg::rsp_type rsp_in, rsp_ff;
   logic              req_valid_ff, req_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_stage_ready;
   logic              rsp_stage_ready;

   slfu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   slfu_core u_core (
      .req (req_ff),
      .cfg (cfg),
      .rsp (rsp_in)
   );

   assign rsp_stage_ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_stage_ready = !req_valid_ff || rsp_stage_ready;
   assign req_ch.ready    = req_stage_ready;

   always_comb begin
      req_in.load_addr       = req_ch.load_addr;
      req_in.load_size_code  = req_ch.load_size_code;
      req_in.load_value      = req_ch.load_value;
      req_in.store_addr      = req_ch.store_addr;
      req_in.store_size_code = req_ch.store_size_code;
      req_in.store_value     = req_ch.store_value;
   end

   assign req_valid_in = req_stage_ready ? req_ch.valid : req_valid_ff;
   assign rsp_valid_in = rsp_stage_ready ? req_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_stage_ready && req_ch.valid) begin
         req_ff <= req_in;
      end
      if (rsp_stage_ready && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.overlap         = rsp_ff.overlap;
   assign rsp_ch.aligned_overlap = rsp_ff.aligned_overlap;
   assign rsp_ch.load_inside     = rsp_ff.load_inside;
   assign rsp_ch.forward_value   = rsp_ff.forward_value;
   assign rsp_ch.merged_value    = rsp_ff.merged_value;

   a_fwd_needs_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.forward_value != '0)) |-> rsp_ch.load_inside)
      else $error("forwarded value without load inside store");

   a_empty_stage_takes: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |-> req_ch.ready)
      else $error("request stalled with empty request stage");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

   a_stage_feeds_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rsp_stage_ready) |=> rsp_ch.valid)
      else $error("request in flight was lost");

endmodule
`default_nettype wire

### test/tb_store_load_forwarding_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_store_load_forwarding_unit
// Drives load/store pairs through the forwarding unit under several
// endianness and alignment settings and with random gaps on both sides.
// Checks every result against an in-bench forwarding/merge computation.
// ----------------------------------------------------------------------------
module tb_store_load_forwarding_unit;

   // Expected forwarding results, computed from the current register settings.
   class forwarding_scoreboard;
      slfu_pkg::cfg_type cfg;
      slfu_pkg::rsp_type expected_results[$];
      int                failures;

      function new();
         cfg      = '0;
         failures = 0;
      endfunction

      // Reverse the low n bytes of v; bytes above n become zero.
      function logic [slfu_pkg::DATA_W-1:0] reverse_bytes(
            logic [slfu_pkg::DATA_W-1:0] v, int n);
         logic [slfu_pkg::DATA_W-1:0] r;
         int k;
         r = '0;
         for (k = 0; k < n; k++) begin
            r[8*(n-1-k) +: 8] = v[8*k +: 8];
         end
         return r;
      endfunction

      function slfu_pkg::rsp_type predict_forwarding(slfu_pkg::req_type r);
         slfu_pkg::rsp_type           res;
         logic [slfu_pkg::ADDR_W-1:0] load_end;
         logic [slfu_pkg::ADDR_W-1:0] store_end;
         logic [slfu_pkg::ADDR_W-1:0] block_mask;
         logic [slfu_pkg::ADDR_W-1:0] gap;
         logic [slfu_pkg::DATA_W-1:0] store_image;
         logic [slfu_pkg::DATA_W-1:0] part;
         int load_bytes;
         int store_bytes;
         int pos;
         int i;
         load_bytes  = 1 << r.load_size_code;
         store_bytes = 1 << r.store_size_code;
         load_end    = r.load_addr + 64'(load_bytes);
         store_end   = r.store_addr + 64'(store_bytes);
         block_mask  = ~((64'd1 << cfg.alignment_log2) - 64'd1);

         res.overlap = (r.load_addr <= r.store_addr && r.store_addr < load_end) ||
                       (r.store_addr <= r.load_addr && r.load_addr < store_end);
         res.aligned_overlap = (r.load_addr & block_mask) == (r.store_addr & block_mask);
         res.load_inside = (r.store_addr <= r.load_addr) && (load_end <= store_end);

         store_image = cfg.little_endian ? r.store_value
                                         : reverse_bytes(r.store_value, store_bytes);

         // a wrapped inside with a far offset shifts everything out
         res.forward_value = '0;
         gap = r.load_addr - r.store_addr;
         if (res.load_inside && gap < 64'd8) begin
            part = store_image >> (8 * gap);
            if (load_bytes < 8) begin
               part &= (64'd1 << (8 * load_bytes)) - 64'd1;
            end
            res.forward_value = cfg.little_endian ? part : reverse_bytes(part, load_bytes);
         end

         // merge uses the plain distance, no wrap
         res.merged_value = r.load_value;
         if (r.load_addr < r.store_addr) begin
            gap = r.store_addr - r.load_addr;
            if (gap < 64'd8) begin
               for (i = 0; i < store_bytes; i++) begin
                  pos = i + int'(gap);
                  if (pos < load_bytes) begin
                     res.merged_value[8*pos +: 8] = store_image[8*i +: 8];
                  end
               end
            end
         end else begin
            gap = r.load_addr - r.store_addr;
            for (i = 0; i < store_bytes; i++) begin
               if (64'(i) >= gap && 64'(i) - gap < 64'(load_bytes)) begin
                  pos = i - int'(gap);
                  res.merged_value[8*pos +: 8] = store_image[8*i +: 8];
               end
            end
         end
         return res;
      endfunction

      function void note_request(slfu_pkg::req_type r);
         expected_results.push_back(predict_forwarding(r));
      endfunction

      function void check_result(slfu_pkg::rsp_type got);
         slfu_pkg::rsp_type want;
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("ERROR: result with no request outstanding");
            end
            return;
         end
         want = expected_results.pop_front();
         if (got.overlap !== want.overlap || got.aligned_overlap !== want.aligned_overlap ||
             got.load_inside !== want.load_inside ||
             got.forward_value !== want.forward_value ||
             got.merged_value !== want.merged_value) begin
            failures++;
            if (failures <= 10) begin
               $display("ERROR: ovl exp %b got %b, aligned exp %b got %b, inside exp %b got %b",
                        want.overlap, got.overlap, want.aligned_overlap,
                        got.aligned_overlap, want.load_inside, got.load_inside);
               $display("       forward exp %h got %h, merged exp %h got %h",
                        want.forward_value, got.forward_value,
                        want.merged_value, got.merged_value);
            end
         end
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction
   endclass

   localparam int NUM_PHASES = 8;
   localparam int PHASE_LITTLE [NUM_PHASES] = '{0, 1, 0, 1, 1, 0, 0, 1};
   localparam int PHASE_ALIGN  [NUM_PHASES] = '{0, 63, 3, 12, 0, 63, 6, 2};
   localparam int PHASE_IDLE   [NUM_PHASES] = '{0, 78, 0, 19, 0, 78, 0, 19};
   localparam int PHASE_STALL  [NUM_PHASES] = '{0, 0, 78, 19, 0, 0, 78, 19};
   localparam int PHASE_ITEMS  = 131;
   localparam int PAUSE_PHASE  = 4;

   logic clock = 1'b0;
   logic reset;

   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [slfu_pkg::CSR_ADDR_W-1:0] paddr;
   logic [slfu_pkg::CSR_DATA_W-1:0] pwdata;
   logic [slfu_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   slfu_req_if req_if ();
   slfu_rsp_if rsp_if ();

   forwarding_scoreboard sb = new();

   slfu_pkg::req_type pending_requests[$];
   int                stall_pct    = 0;
   int                holdoff_left = 0;

   store_load_forwarding_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

   // Result side: take results, stall at random or for a long hold-off.
   initial begin
      slfu_pkg::rsp_type got;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.overlap         = rsp_if.overlap;
            got.aligned_overlap = rsp_if.aligned_overlap;
            got.load_inside     = rsp_if.load_inside;
            got.forward_value   = rsp_if.forward_value;
            got.merged_value    = rsp_if.merged_value;
            sb.check_result(got);
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic void add_request(logic [63:0] la, logic [1:0] lc, logic [63:0] lv,
                                       logic [63:0] sa, logic [1:0] sc, logic [63:0] sv);
      slfu_pkg::req_type r;
      r.load_addr       = la;
      r.load_size_code  = lc;
      r.load_value      = lv;
      r.store_addr      = sa;
      r.store_size_code = sc;
      r.store_value     = sv;
      pending_requests.push_back(r);
   endfunction

   // Mostly nearby pairs so the overlap and merge paths see real work.
   function automatic void add_random_requests(int count);
      logic [63:0] base;
      logic [63:0] load_addr;
      int kind;
      int offset;
      int n;
      for (n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         base = {$urandom, $urandom};
         if (kind < 12) begin
            base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(15));
         end else if (kind < 18) begin
            base = 64'($urandom_range(15));
         end
         if (kind < 85) begin
            offset    = $urandom_range(24) - 12;
            load_addr = base + 64'(offset);
         end else begin
            load_addr = {$urandom, $urandom};
         end
         add_request(load_addr, 2'($urandom_range(3)), {$urandom, $urandom},
                     base, 2'($urandom_range(3)), {$urandom, $urandom});
      end
   endfunction

   task automatic drive_requests(input int idle_pct);
      slfu_pkg::req_type item;
      bit                busy;
      busy = 1'b0;
      while (busy || pending_requests.size() != 0) begin
         @(posedge clock);
         if (busy && req_if.ready) begin
            sb.note_request(item);
            busy = 1'b0;
         end
         if (!busy) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
               item = pending_requests.pop_front();
               req_if.load_addr       <= item.load_addr;
               req_if.load_size_code  <= item.load_size_code;
               req_if.load_value      <= item.load_value;
               req_if.store_addr      <= item.store_addr;
               req_if.store_size_code <= item.store_size_code;
               req_if.store_value     <= item.store_value;
               req_if.valid           <= 1'b1;
               busy = 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write a register, read it back, then track the new setting.
   task automatic set_register(input logic index,
                               input logic [slfu_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      psel    <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value) begin
         sb.failures++;
         if (sb.failures <= 10) begin
            $display("ERROR: register %0d read exp %h got %h", index, value, prdata);
         end
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      if (index == slfu_pkg::REG_LITTLE_ENDIAN) begin
         sb.cfg.little_endian = value[0];
      end else begin
         sb.cfg.alignment_log2 = value[slfu_pkg::ALIGN_W-1:0];
      end
   endtask

   initial begin
      int p;
      reset                  <= 1'b1;
      psel                   <= 1'b0;
      penable                <= 1'b0;
      pwrite                 <= 1'b0;
      paddr                  <= '0;
      pwdata                 <= '0;
      req_if.valid           <= 1'b0;
      req_if.load_addr       <= '0;
      req_if.load_size_code  <= slfu_pkg::SIZE_1;
      req_if.load_value      <= '0;
      req_if.store_addr      <= '0;
      req_if.store_size_code <= slfu_pkg::SIZE_1;
      req_if.store_value     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed pairs under the reset setting: big endian, one-byte blocks
      add_request(64'h0, slfu_pkg::SIZE_1, 64'h0, 64'h0, slfu_pkg::SIZE_1, 64'h0);
      add_request('1, slfu_pkg::SIZE_8, '1, '1, slfu_pkg::SIZE_8, '1);
      add_request(64'h1000, slfu_pkg::SIZE_8, 64'h1111_2222_3333_4444,
                  64'h1000, slfu_pkg::SIZE_8, 64'h0123_4567_89AB_CDEF);
      add_request(64'h1004, slfu_pkg::SIZE_4, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'h1000, slfu_pkg::SIZE_8, 64'h0123_4567_89AB_CDEF);
      add_request(64'h1001, slfu_pkg::SIZE_1, 64'h0,
                  64'h1000, slfu_pkg::SIZE_2, 64'hFFFF_FFFF_FFFF_A55A);
      add_request(64'h1000, slfu_pkg::SIZE_1, 64'hDEAD_BEEF_CAFE_F00D,
                  64'h1000, slfu_pkg::SIZE_8, 64'h0123_4567_89AB_CDEF);
      add_request(64'h0FFC, slfu_pkg::SIZE_8, 64'h0,
                  64'h1000, slfu_pkg::SIZE_8, 64'h0123_4567_89AB_CDEF);
      add_request(64'h1004, slfu_pkg::SIZE_8, 64'h0,
                  64'h1000, slfu_pkg::SIZE_8, 64'h0123_4567_89AB_CDEF);
      add_request(64'h1000, slfu_pkg::SIZE_8, 64'h5555_5555_5555_5555,
                  64'h1002, slfu_pkg::SIZE_2, 64'hAAAA_AAAA_AAAA_1234);
      add_request(64'h1008, slfu_pkg::SIZE_8, 64'h0, 64'h1000, slfu_pkg::SIZE_8, '1);
      add_request(64'h1000, slfu_pkg::SIZE_4, 64'h0, 64'h2000, slfu_pkg::SIZE_4, '1);
      add_request(64'h0100, slfu_pkg::SIZE_8, 64'h0, 64'h0108, slfu_pkg::SIZE_8, '1);
      add_request(64'hFFFF_FFFF_FFFF_FFFE, slfu_pkg::SIZE_1, 64'h0,
                  64'hFFFF_FFFF_FFFF_FFFC, slfu_pkg::SIZE_8, 64'h8877_6655_4433_2211);
      add_request(64'h0, slfu_pkg::SIZE_1, '1,
                  64'hFFFF_FFFF_FFFF_FFFC, slfu_pkg::SIZE_8, 64'h0);
      // inside only through wrap, offset too far to forward anything
      add_request('1, slfu_pkg::SIZE_1, 64'h0, 64'h0, slfu_pkg::SIZE_1, '1);
      add_request('1, slfu_pkg::SIZE_8, 64'h0, 64'h0, slfu_pkg::SIZE_8, '1);
      // small offset; both ranges wrap in the first two pairs
      add_request(64'hFFFF_FFFF_FFFF_FFFE, slfu_pkg::SIZE_4, 64'h0,
                  64'hFFFF_FFFF_FFFF_FFFC, slfu_pkg::SIZE_8, 64'h0123_4567_89AB_CDEF);
      add_request(64'hFFFF_FFFF_FFFF_FFFC, slfu_pkg::SIZE_4, 64'h0,
                  64'hFFFF_FFFF_FFFF_FFF8, slfu_pkg::SIZE_8, 64'h0123_4567_89AB_CDEF);
      add_request(64'h7FFF_FFFF_FFFF_FFFF, slfu_pkg::SIZE_2, 64'h0,
                  64'h8000_0000_0000_0000, slfu_pkg::SIZE_2, 64'hFFFF);
      drive_requests(0);
      wait_drained();

      for (p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) begin
            set_register(slfu_pkg::REG_LITTLE_ENDIAN,
                         slfu_pkg::CSR_DATA_W'(PHASE_LITTLE[p]));
            set_register(slfu_pkg::REG_ALIGN_LOG2,
                         slfu_pkg::CSR_DATA_W'(PHASE_ALIGN[p]));
         end
         stall_pct = PHASE_STALL[p];
         if (p == PAUSE_PHASE) begin
            // hold the result side off while requests keep coming, then pause
            holdoff_left = 80;
            add_random_requests(PHASE_ITEMS / 2);
            drive_requests(PHASE_IDLE[p]);
            wait_drained();
            add_random_requests(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            add_random_requests(PHASE_ITEMS);
         end
         drive_requests(PHASE_IDLE[p]);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### store_load_forwarding_unit.f
rtl/slfu_pkg.sv
rtl/slfu_req_if.sv
rtl/slfu_rsp_if.sv
rtl/slfu_csr.sv
rtl/slfu_core.sv
rtl/store_load_forwarding_unit.sv
test/tb_store_load_forwarding_unit.sv
